[sv/xmodem_checksum_transfer_macros.svh]
// Assertion macros used by the checker file.
`ifndef XMODEM_CHECKSUM_TRANSFER_MACROS_SVH
`define XMODEM_CHECKSUM_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define XCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xct assertion failed");

// Next-cycle implication, disabled while reset is low.
`define XCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xct assertion failed");

`endif

[sv/xct_pkg.sv]
package xct_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int POS_W       = 8;
    localparam int CNT_W       = 12;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES + 3);

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [7:0] ACK_CODE = 8'h06;
    localparam logic [7:0] NAK_CODE = 8'h15;
    localparam logic [7:0] CAN_CODE = 8'h18;

    typedef enum logic [2:0] {
        CMD_START_RX = 3'd0,
        CMD_START_TX = 3'd1,
        CMD_RX_BYTE  = 3'd2,
        CMD_TX_EMPTY = 3'd3,
        CMD_LOAD     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_RX      = 2'd1,
        MODE_TXWAIT  = 2'd2,
        MODE_TX      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_RESEND    = 3'd2,
        ST_FINISHED  = 3'd3,
        ST_CANCELLED = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]       command;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] load_index;
        logic [7:0]       load_byte;
    } t_in_word;

    typedef struct packed {
        logic             send_valid;
        logic [7:0]       send_byte;
        logic             store_valid;
        logic [IDX_W-1:0] store_index;
        logic [7:0]       store_byte;
        logic [2:0]       block_status;
        logic [CNT_W-1:0] block_number;
        logic [1:0]       engine_mode;
    } t_out_word;

    typedef logic [CNT_W-1:0] t_cfg_word;

endpackage

[sv/xct_chan_if.sv]
interface xct_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/xmodem_checksum_transfer.sv]
// XMODEM engine, 128-byte blocks with an 8-bit additive checksum.
// i_in carries one command word per handshake: start receive, start
// transmit, byte received, transmitter empty, or load a transmit store byte.
// o_out returns exactly one result word for each accepted command word:
// the byte for the serial transmitter, a received payload byte, the block
// status, the block counter and the engine mode. i_cfg writes the number of
// blocks to send before EOT; write it only while the engine is idle.
// After its command word is accepted, the result word passes through one
// input register, then the decode and update logic into the result register.
// Throughput is one word per cycle while o_out is not stalled; the transmit
// store is a 128-byte RAM whose read address is prefetched from the next
// byte position, with a bypass for a load to the same address.
// Synchronous active-low reset returns the engine to standby, clears the
// counters and the transmitter-empty flag; the transmit store holds
// whatever was last loaded. No word is taken while reset is low. When o_out
// is stalled the result register holds and i_in accepts one more word into
// the input register, then stalls too.
module xmodem_checksum_transfer (
    input logic         i_clk,
    input logic         i_rst_n,
    xct_chan_if.sink    i_in,
    xct_chan_if.source  o_out,
    xct_chan_if.sink    i_cfg
);
    localparam int IW = xct_pkg::IDX_W;
    localparam int PW = xct_pkg::POS_W;
    localparam int CW = xct_pkg::CNT_W;

    logic                  r_in_valid;
    xct_pkg::t_in_word     r_in;
    logic                  r_out_valid;
    xct_pkg::t_out_word    r_out;
    xct_pkg::t_mode        r_mode, n_mode;
    logic [PW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [7:0]            r_sum, n_sum;
    logic                  r_empty, n_empty;
    logic [CW-1:0]         r_tx_count;
    logic                  r_fwd_hit;
    logic [7:0]            r_fwd_data;

    logic                  advance;
    logic [CW-1:0]         cnt_inc, cnt_dec;
    logic [PW-1:0]         pos_m3, pos_eff, rd_diff;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [7:0]            ram_q, tx_byte;
    logic                  emit_req, empty_now, tx_go, send;
    logic [7:0]            emit_val;
    xct_pkg::t_status      status;
    logic                  st_valid;
    logic [7:0]            st_byte;
    xct_pkg::t_out_word    n_out;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = i_rst_n && (!r_in_valid || advance);
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign cnt_inc = r_cnt + CW'(1);
    assign cnt_dec = r_cnt - CW'(1);
    assign pos_m3  = r_pos - PW'(3);
    assign pos_eff = advance ? n_pos : r_pos;
    assign rd_diff = pos_eff - PW'(3);
    assign rd_addr = rd_diff[IW-1:0];
    assign wr_en   = advance && (r_in.command == xct_pkg::CMD_LOAD);
    assign tx_byte = r_fwd_hit ? r_fwd_data : ram_q;

    xct_ram #(
        .WIDTH (8),
        .DEPTH (xct_pkg::BLOCK_BYTES)
    ) u_tx_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_in.load_index),
        .i_wr_data (r_in.load_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_empty   = r_empty;
        emit_req  = 1'b0;
        emit_val  = 8'd0;
        empty_now = r_empty;
        tx_go     = 1'b0;
        status    = xct_pkg::ST_NONE;
        st_valid  = 1'b0;
        st_byte   = 8'd0;

        case (r_in.command)
            xct_pkg::CMD_START_RX: begin
                n_mode   = xct_pkg::MODE_RX;
                n_pos    = '0;
                n_cnt    = '0;
                emit_req = 1'b1;
                emit_val = xct_pkg::NAK_CODE;
            end
            xct_pkg::CMD_START_TX: begin
                n_mode = xct_pkg::MODE_TXWAIT;
                n_pos  = '0;
                n_cnt  = '0;
            end
            xct_pkg::CMD_RX_BYTE: begin
                case (r_mode)
                    xct_pkg::MODE_RX: begin
                        if (r_pos == PW'(0)) begin
                            n_sum = 8'd0;
                            if (r_in.rx_byte inside {xct_pkg::EOT_CODE, xct_pkg::CAN_CODE}) begin
                                emit_req = 1'b1;
                                emit_val = xct_pkg::ACK_CODE;
                                n_mode   = xct_pkg::MODE_STANDBY;
                                status   = (r_in.rx_byte == xct_pkg::EOT_CODE) ?
                                           xct_pkg::ST_FINISHED : xct_pkg::ST_CANCELLED;
                            end else if (r_in.rx_byte == xct_pkg::SOH_CODE) begin
                                n_pos = PW'(1);
                            end
                        end else if (r_pos == PW'(1)) begin
                            if (r_in.rx_byte == cnt_inc[7:0]) begin
                                n_cnt = cnt_inc;
                                n_pos = PW'(2);
                            end else begin
                                n_pos    = '0;
                                emit_req = 1'b1;
                                emit_val = xct_pkg::NAK_CODE;
                                status   = xct_pkg::ST_RESEND;
                            end
                        end else if (r_pos == PW'(2)) begin
                            if (r_in.rx_byte == ~r_cnt[7:0]) begin
                                n_pos = PW'(3);
                            end else begin
                                n_pos    = '0;
                                n_cnt    = cnt_dec;
                                emit_req = 1'b1;
                                emit_val = xct_pkg::NAK_CODE;
                                status   = xct_pkg::ST_RESEND;
                            end
                        end else if (r_pos < xct_pkg::LAST_POS) begin
                            st_valid = 1'b1;
                            st_byte  = r_in.rx_byte;
                            n_sum    = r_sum + r_in.rx_byte;
                            n_pos    = r_pos + PW'(1);
                        end else begin
                            n_pos    = '0;
                            emit_req = 1'b1;
                            if (r_in.rx_byte == r_sum) begin
                                emit_val = xct_pkg::ACK_CODE;
                                status   = xct_pkg::ST_ACCEPTED;
                            end else begin
                                n_cnt    = cnt_dec;
                                emit_val = xct_pkg::NAK_CODE;
                                status   = xct_pkg::ST_RESEND;
                            end
                        end
                    end
                    xct_pkg::MODE_TXWAIT: begin
                        if (r_in.rx_byte == xct_pkg::NAK_CODE) begin
                            n_mode = xct_pkg::MODE_TX;
                            tx_go  = 1'b1;
                        end
                    end
                    xct_pkg::MODE_TX: begin
                        if (r_in.rx_byte == xct_pkg::NAK_CODE) begin
                            n_pos  = '0;
                            n_cnt  = cnt_dec;
                            status = xct_pkg::ST_RESEND;
                        end else if (r_in.rx_byte == xct_pkg::CAN_CODE) begin
                            emit_req = 1'b1;
                            emit_val = xct_pkg::ACK_CODE;
                            n_mode   = xct_pkg::MODE_STANDBY;
                            status   = xct_pkg::ST_CANCELLED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            xct_pkg::CMD_TX_EMPTY: begin
                empty_now = 1'b1;
                n_empty   = 1'b1;
                tx_go     = (r_mode == xct_pkg::MODE_TX);
            end
            default: begin
            end
        endcase

        if (tx_go) begin
            emit_req = 1'b1;
            if (r_pos == PW'(0)) begin
                n_sum = 8'd0;
                n_pos = PW'(1);
                if (r_cnt == r_tx_count) begin
                    emit_val = xct_pkg::EOT_CODE;
                    n_mode   = xct_pkg::MODE_STANDBY;
                    status   = xct_pkg::ST_FINISHED;
                end else begin
                    emit_val = xct_pkg::SOH_CODE;
                end
            end else if (r_pos == PW'(1)) begin
                n_cnt    = cnt_inc;
                emit_val = cnt_inc[7:0];
                n_pos    = PW'(2);
            end else if (r_pos == PW'(2)) begin
                emit_val = ~r_cnt[7:0];
                n_pos    = PW'(3);
            end else if (r_pos < xct_pkg::LAST_POS) begin
                emit_val = tx_byte;
                n_sum    = r_sum + tx_byte;
                n_pos    = r_pos + PW'(1);
            end else begin
                emit_val = r_sum;
                n_pos    = '0;
            end
        end

        send = emit_req && empty_now;
        if (send) begin
            n_empty = 1'b0;
        end

        n_out.send_valid   = send;
        n_out.send_byte    = send ? emit_val : 8'd0;
        n_out.store_valid  = st_valid;
        n_out.store_index  = st_valid ? pos_m3[IW-1:0] : '0;
        n_out.store_byte   = st_byte;
        n_out.block_status = status;
        n_out.block_number = n_cnt;
        n_out.engine_mode  = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= xct_pkg::MODE_STANDBY;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sum       <= 8'd0;
            r_empty     <= 1'b0;
            r_tx_count  <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_pos       <= n_pos;
                r_cnt       <= n_cnt;
                r_sum       <= n_sum;
                r_empty     <= n_empty;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_tx_count <= i_cfg.data;
            end
            r_fwd_hit <= wr_en && (r_in.load_index == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
        r_fwd_data <= r_in.load_byte;
    end
endmodule

[sv/xct_ram.sv]
module xct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = xct_pkg::BLOCK_BYTES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[sv/xct_checker.sv]
`include "xmodem_checksum_transfer_macros.svh"

module xct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input xct_pkg::t_out_word i_out_data
);
    `XCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))
    `XCT_ASSERT_IMPL(a_send_idle_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.send_valid, i_out_data.send_byte == 8'd0)
    `XCT_ASSERT_IMPL(a_store_in_rx, i_clk, i_rst_n, i_out_valid && i_out_data.store_valid, (i_out_data.engine_mode == xct_pkg::MODE_RX) && !i_out_data.send_valid && (i_out_data.block_status == xct_pkg::ST_NONE))
    `XCT_ASSERT_IMPL(a_end_standby, i_clk, i_rst_n, i_out_valid && ((i_out_data.block_status == xct_pkg::ST_FINISHED) || (i_out_data.block_status == xct_pkg::ST_CANCELLED)), i_out_data.engine_mode == xct_pkg::MODE_STANDBY)
endmodule

bind xmodem_checksum_transfer xct_checker u_xct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[tb/testbench.sv]
import xct_pkg::*;

module testbench;

    localparam int STALL_LIMIT   = 2000;
    localparam int END_CYCLES    = 8;
    localparam int RANDOM_WORDS  = 600;
    localparam int LONG_HOLD     = 200;

    typedef enum int {
        SINK_OPEN,
        SINK_SPARSE,
        SINK_THIRDS,
        SINK_TOGGLE
    } t_sink_pattern;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xct_chan_if #(.T(t_in_word))  in_ch ();
    xct_chan_if #(.T(t_out_word)) out_ch ();
    xct_chan_if #(.T(t_cfg_word)) cfg_ch ();

    xmodem_checksum_transfer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_mode            eng_mode;
    logic [POS_W-1:0] frame_pos;
    logic [CNT_W-1:0] blk_cnt;
    logic [7:0]       frame_sum;
    logic             line_free;
    logic [7:0]       tx_image [BLOCK_BYTES];
    t_cfg_word        blocks_to_send;
    t_out_word        step_word;

    t_out_word     pending_results [$];
    t_out_word     want_word;
    t_out_word     got_word;
    int            mismatches   = 0;
    int            idle_cycles  = 0;
    int            words_sent   = 0;
    int            burst_left   = 0;
    int            hold_cycles  = 0;
    int            pattern_left = 0;
    bit            no_gaps      = 1'b0;
    t_sink_pattern sink_pattern = SINK_OPEN;

    always #5 i_clk = ~i_clk;

    function automatic void put_line(logic [7:0] b);
        if (line_free) begin
            line_free = 1'b0;
            step_word.send_valid = 1'b1;
            step_word.send_byte = b;
        end
    endfunction

    function automatic void tx_advance();
        logic [7:0] v;
        v = 8'h00;
        if (frame_pos == 0) begin
            frame_sum = 8'h00;
            if (blk_cnt == blocks_to_send) begin
                v = EOT_CODE;
                eng_mode = MODE_STANDBY;
                step_word.block_status = ST_FINISHED;
            end else begin
                v = SOH_CODE;
            end
            frame_pos = 1;
        end else if (frame_pos == 1) begin
            blk_cnt = blk_cnt + 1'b1;
            v = blk_cnt[7:0];
            frame_pos = 2;
        end else if (frame_pos == 2) begin
            v = ~blk_cnt[7:0];
            frame_pos = 3;
        end else if (frame_pos < LAST_POS) begin
            v = tx_image[IDX_W'(frame_pos - 8'd3)];
            frame_sum = frame_sum + v;
            frame_pos = frame_pos + 1'b1;
        end else begin
            v = frame_sum;
            frame_pos = 0;
        end
        put_line(v);
    endfunction

    function automatic void rx_take(logic [7:0] b);
        bit ok;
        ok = 1'b1;
        if (frame_pos == 0) begin
            frame_sum = 8'h00;
            if (b == EOT_CODE || b == CAN_CODE) begin
                put_line(ACK_CODE);
                eng_mode = MODE_STANDBY;
                step_word.block_status = (b == EOT_CODE) ? ST_FINISHED : ST_CANCELLED;
                return;
            end
            if (b != SOH_CODE) begin
                return;
            end
            frame_pos = 1;
        end else if (frame_pos == 1) begin
            blk_cnt = blk_cnt + 1'b1;
            ok = (b == blk_cnt[7:0]);
            frame_pos = 2;
        end else if (frame_pos == 2) begin
            ok = (b == ~blk_cnt[7:0]);
            frame_pos = 3;
        end else if (frame_pos < LAST_POS) begin
            step_word.store_valid = 1'b1;
            step_word.store_index = IDX_W'(frame_pos - 8'd3);
            step_word.store_byte = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 1'b1;
        end else begin
            frame_pos = 0;
            if (b != frame_sum) begin
                ok = 1'b0;
            end else begin
                put_line(ACK_CODE);
                step_word.block_status = ST_ACCEPTED;
            end
        end
        if (!ok) begin
            frame_pos = 0;
            blk_cnt = blk_cnt - 1'b1;
            put_line(NAK_CODE);
            step_word.block_status = ST_RESEND;
        end
    endfunction

    function automatic t_out_word engine_response(t_in_word w);
        step_word = '0;
        case (w.command)
            CMD_START_RX: begin
                eng_mode = MODE_RX;
                frame_pos = 0;
                blk_cnt = 0;
                put_line(NAK_CODE);
            end
            CMD_START_TX: begin
                eng_mode = MODE_TXWAIT;
                frame_pos = 0;
                blk_cnt = 0;
            end
            CMD_RX_BYTE: begin
                if (eng_mode == MODE_RX) begin
                    rx_take(w.rx_byte);
                end else if (eng_mode == MODE_TXWAIT) begin
                    if (w.rx_byte == NAK_CODE) begin
                        eng_mode = MODE_TX;
                        tx_advance();
                    end
                end else if (eng_mode == MODE_TX) begin
                    if (w.rx_byte == NAK_CODE) begin
                        frame_pos = 0;
                        blk_cnt = blk_cnt - 1'b1;
                        step_word.block_status = ST_RESEND;
                    end else if (w.rx_byte == CAN_CODE) begin
                        put_line(ACK_CODE);
                        eng_mode = MODE_STANDBY;
                        step_word.block_status = ST_CANCELLED;
                    end
                end
            end
            CMD_TX_EMPTY: begin
                line_free = 1'b1;
                if (eng_mode == MODE_TX) begin
                    tx_advance();
                end
            end
            CMD_LOAD: begin
                tx_image[w.load_index] = w.load_byte;
            end
            default: begin
            end
        endcase
        step_word.block_number = blk_cnt;
        step_word.engine_mode = eng_mode;
        return step_word;
    endfunction

    function automatic void match_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got_word = out_ch.data;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, expected none, actual %h",
                         $time, got_word);
            end else begin
                want_word = pending_results.pop_front();
                match_field("send_valid", want_word.send_valid, got_word.send_valid);
                match_field("send_byte", want_word.send_byte, got_word.send_byte);
                match_field("store_valid", want_word.store_valid, got_word.store_valid);
                match_field("store_index", want_word.store_index, got_word.store_index);
                match_field("store_byte", want_word.store_byte, got_word.store_byte);
                match_field("block_status", want_word.block_status, got_word.block_status);
                match_field("block_number", want_word.block_number, got_word.block_number);
                match_field("engine_mode", want_word.engine_mode, got_word.engine_mode);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles--;
        end else begin
            if (pattern_left == 0) begin
                sink_pattern = t_sink_pattern'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end else begin
                pattern_left--;
            end
            case (sink_pattern)
                SINK_OPEN:   out_ch.ready <= 1'b1;
                SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 9) >= 3);
                SINK_THIRDS: out_ch.ready <= ($urandom_range(0, 2) == 0);
                default:     out_ch.ready <= ~out_ch.ready;
            endcase
        end
    end

    function automatic t_in_word word_of(t_cmd c, logic [7:0] rx);
        t_in_word w;
        w.command = c;
        w.rx_byte = rx;
        w.load_index = IDX_W'($urandom);
        w.load_byte = 8'($urandom);
        return w;
    endfunction

    function automatic logic [7:0] flip_bit();
        return 8'(1 << $urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] pick_rx_byte();
        case ($urandom_range(0, 7))
            0:       return SOH_CODE;
            1:       return EOT_CODE;
            2:       return ACK_CODE;
            3:       return NAK_CODE;
            4:       return CAN_CODE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        in_ch.data <= w;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_results.push_back(engine_response(w));
        words_sent++;
        @(negedge i_clk);
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_cmd(t_cmd c, logic [7:0] rx);
        send_word(word_of(c, rx));
    endtask

    task automatic send_load(logic [IDX_W-1:0] idx, logic [7:0] val);
        t_in_word w;
        w = word_of(CMD_LOAD, 8'($urandom));
        w.load_index = idx;
        w.load_byte = val;
        send_word(w);
    endtask

    task automatic maybe_free_line();
        if ($urandom_range(0, 1) == 0) begin
            send_cmd(CMD_TX_EMPTY, 8'($urandom));
        end
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_word value);
        wait_drain();
        cfg_ch.data <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        blocks_to_send = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic receive_block();
        bit         done;
        logic [7:0] num;
        logic [7:0] sum;
        logic [7:0] b;
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(0, 4) == 0) begin
                b = 8'($urandom);
                if (b != SOH_CODE && b != EOT_CODE && b != CAN_CODE) begin
                    send_cmd(CMD_RX_BYTE, b);
                end
            end
            maybe_free_line();
            send_cmd(CMD_RX_BYTE, SOH_CODE);
            num = blk_cnt[7:0] + 8'd1;
            if ($urandom_range(0, 11) == 0) begin
                send_cmd(CMD_RX_BYTE, num ^ flip_bit());
                continue;
            end
            send_cmd(CMD_RX_BYTE, num);
            if ($urandom_range(0, 11) == 0) begin
                send_cmd(CMD_RX_BYTE, ~num ^ flip_bit());
                continue;
            end
            send_cmd(CMD_RX_BYTE, ~num);
            sum = 8'h00;
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                b = 8'($urandom);
                if ($urandom_range(0, 7) == 0) begin
                    send_cmd(CMD_TX_EMPTY, 8'($urandom));
                end
                send_cmd(CMD_RX_BYTE, b);
                sum = sum + b;
            end
            maybe_free_line();
            if ($urandom_range(0, 7) == 0) begin
                send_cmd(CMD_RX_BYTE, sum ^ flip_bit());
            end else begin
                send_cmd(CMD_RX_BYTE, sum);
                done = 1'b1;
            end
        end
    endtask

    task automatic receive_session();
        int blocks;
        blocks = $urandom_range(1, 3);
        send_cmd(CMD_START_RX, 8'($urandom));
        for (int k = 0; k < blocks; k++) begin
            receive_block();
        end
        maybe_free_line();
        send_cmd(CMD_RX_BYTE, ($urandom_range(0, 3) == 0) ? CAN_CODE : EOT_CODE);
    endtask

    task automatic transmit_session();
        int guard;
        int r;
        int reloads;
        cfg_write(t_cfg_word'($urandom_range(1, 2)));
        reloads = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, BLOCK_BYTES);
        repeat (reloads) send_load(IDX_W'($urandom), 8'($urandom));
        send_cmd(CMD_START_TX, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            send_cmd(CMD_RX_BYTE, ACK_CODE);
        end
        maybe_free_line();
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        guard = 0;
        while (eng_mode == MODE_TX && guard < 1000) begin
            r = $urandom_range(0, 299);
            if (r == 0) begin
                send_cmd(CMD_RX_BYTE, NAK_CODE);
            end else if (r == 1) begin
                send_cmd(CMD_RX_BYTE, CAN_CODE);
            end else if (r < 8) begin
                send_cmd(CMD_RX_BYTE, 8'($urandom));
            end else begin
                send_cmd(CMD_TX_EMPTY, 8'($urandom));
            end
            guard++;
        end
    endtask

    task automatic noise_burst();
        t_in_word w;
        repeat ($urandom_range(8, 32)) begin
            w = word_of(t_cmd'($urandom_range(0, 7)), pick_rx_byte());
            send_word(w);
        end
    endtask

    task automatic test_receive_handshake();
        cfg_write(12'd0);
        send_cmd(CMD_RX_BYTE, SOH_CODE);
        send_cmd(CMD_RX_BYTE, 8'hFF);
        send_cmd(CMD_START_RX, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, 8'h55);
        send_cmd(CMD_RX_BYTE, SOH_CODE);
        send_cmd(CMD_RX_BYTE, 8'h02);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, SOH_CODE);
        send_cmd(CMD_RX_BYTE, 8'h01);
        send_cmd(CMD_RX_BYTE, 8'hFF);
        send_cmd(CMD_RX_BYTE, SOH_CODE);
        send_cmd(CMD_RX_BYTE, 8'h01);
        send_cmd(CMD_RX_BYTE, 8'hFE);
        send_cmd(CMD_START_RX, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, EOT_CODE);
        send_cmd(CMD_START_RX, 8'h00);
        send_cmd(CMD_RX_BYTE, CAN_CODE);
    endtask

    task automatic test_transmit_end();
        send_cmd(CMD_START_TX, 8'h00);
        send_cmd(CMD_RX_BYTE, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        send_load(7'd127, 8'hFF);
        send_load(7'd0, 8'h00);
    endtask

    task automatic test_counter_wrap();
        cfg_write(12'd5);
        send_cmd(CMD_START_TX, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_TX_EMPTY, 8'h00);
        send_cmd(CMD_RX_BYTE, CAN_CODE);
    endtask

    task automatic test_output_stall();
        wait_drain();
        hold_cycles = LONG_HOLD;
        no_gaps = 1'b1;
        send_cmd(CMD_START_RX, 8'($urandom));
        send_cmd(CMD_TX_EMPTY, 8'($urandom));
        send_cmd(CMD_RX_BYTE, SOH_CODE);
        repeat (40) send_cmd(CMD_RX_BYTE, 8'($urandom));
        no_gaps = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_transfers();
        int start;
        start = words_sent;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            send_load(IDX_W'(i), 8'($urandom));
        end
        while (words_sent - start < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: receive_session();
                5, 6, 7:       transmit_session();
                default:       noise_burst();
            endcase
        end
    endtask

    task automatic test_long_count();
        cfg_write(12'd3072);
        send_cmd(CMD_START_TX, 8'($urandom));
        send_cmd(CMD_TX_EMPTY, 8'($urandom));
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        repeat (12) send_cmd(CMD_TX_EMPTY, 8'($urandom));
        send_cmd(CMD_RX_BYTE, CAN_CODE);
        cfg_write(12'd2047);
        send_cmd(CMD_START_TX, 8'($urandom));
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        repeat (6) send_cmd(CMD_TX_EMPTY, 8'($urandom));
        send_cmd(CMD_RX_BYTE, NAK_CODE);
        repeat (4) send_cmd(CMD_TX_EMPTY, 8'($urandom));
        send_cmd(CMD_START_RX, 8'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        eng_mode = MODE_STANDBY;
        frame_pos = '0;
        blk_cnt = '0;
        frame_sum = 8'h00;
        line_free = 1'b0;
        blocks_to_send = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_receive_handshake();
        test_transmit_end();
        test_counter_wrap();
        test_output_stall();
        test_random_transfers();
        test_long_count();

        wait_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
